@@ sv/rria_pkg.sv @@
package rria_pkg;

  // the used map is kept as words of this many bits
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;

  // request and response codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_FULL    = 1'b1;

  // result of the first-free search over one word
  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] onehot;
  } ffz_res_t;

endpackage

@@ sv/rria_ram.sv @@
module rria_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rria_ffz.sv @@
module rria_ffz (
  input  logic [rria_pkg::WORD_W-1:0] word,
  input  logic [rria_pkg::WORD_W-1:0] mask,
  output rria_pkg::ffz_res_t          res
);

  logic [rria_pkg::WORD_W-1:0] free;
  logic [rria_pkg::WORD_W-1:0] lowest;
  logic [rria_pkg::BIT_W-1:0]  idx;

  // lowest set bit of the free vector through one add
  assign free   = ~(word | mask);
  assign lowest = free & (~free + rria_pkg::WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < rria_pkg::WORD_W; i++) begin
      if (lowest[i]) begin
        idx = idx | rria_pkg::BIT_W'(i);
      end
    end
  end

  assign res.found   = |free;
  assign res.bit_idx = idx;
  assign res.onehot  = lowest;

endmodule

@@ sv/round_robin_id_allocator.sv @@
// channel  handshake             payload
// req      req_valid/req_stall   mode, release_id
// rsp      rsp_valid/rsp_stall   granted_id, status
//
// allocate: the request is accepted, then the map ram is scanned word by word from
//   the pointer's word until a free identifier turns up
// free: read-modify-write of one map word; full or out-of-range: answered at accept
// reset: a clearing pass writes every map word, req stalled
// rsp holds its transaction while rsp_stall is high; a new request is taken only
//   when the response register is empty or draining
module round_robin_id_allocator #(
  parameter int ID_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       mode,
  input  logic [7:0] release_id,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] granted_id,
  output logic       status
);

  localparam int WORD_W    = rria_pkg::WORD_W;
  localparam int BIT_W     = rria_pkg::BIT_W;
  localparam int DEPTH     = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W     = $clog2(ID_COUNT);
  localparam int CNT_W     = $clog2(ID_COUNT + 1);
  localparam int LAST_BITS = ID_COUNT - (DEPTH - 1) * WORD_W;
  // identifiers past the pool in the last word always look used
  localparam logic [WORD_W-1:0] TAIL_PAD = ~WORD_W'((2 ** LAST_BITS) - 1);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE,
    S_SCAN
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      op_addr;
  logic [BIT_W-1:0]   op_bit;
  logic               first;
  logic [IDX_W-1:0]   ptr;
  logic [CNT_W-1:0]   used_count;

  logic               req_acc;
  logic               rsp_load;
  logic               full;
  logic               rel_ok;
  logic [AW-1:0]      rel_addr;
  logic [AW-1:0]      ptr_addr;
  logic [AW-1:0]      scan_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [WORD_W-1:0]  scan_mask;
  logic [WORD_W-1:0]  bit_sel;
  logic               bit_set;
  rria_pkg::ffz_res_t ffz;
  logic [IDX_W-1:0]   new_id;
  logic [IDX_W:0]     id_inc;
  logic [IDX_W-1:0]   ptr_next;

  // a new request waits for the sequencer and for room in the response register
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign req_acc   = req_valid && !req_stall;

  assign full      = (used_count == CNT_W'(ID_COUNT));
  assign rel_ok    = (32'(release_id) < 32'(ID_COUNT));
  assign rel_addr  = AW'(release_id >> BIT_W);
  assign ptr_addr  = AW'(ptr >> BIT_W);
  assign scan_next = (op_addr == LAST_ADDR) ? '0 : op_addr + AW'(1);

  // a response transaction is loaded when the current request finishes
  assign rsp_load  = (state == S_FREE) || ((state == S_SCAN) && ffz.found) ||
                     (req_acc && ((mode == rria_pkg::MODE_FREE) ? !rel_ok : full));

  // first word of a scan skips bits below the pointer; on wrap-around all bits count
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      scan_mask[i] = first && (BIT_W'(i) < op_bit);
      bit_sel[i]   = (BIT_W'(i) == op_bit);
    end
    if (op_addr == LAST_ADDR) begin
      scan_mask = scan_mask | TAIL_PAD;
    end
  end

  assign bit_set = |(ram_rdata & bit_sel);

  rria_ffz u_ffz (
    .word (ram_rdata),
    .mask (scan_mask),
    .res  (ffz)
  );

  assign new_id   = IDX_W'({op_addr, ffz.bit_idx});
  assign id_inc   = {1'b0, new_id} + (IDX_W + 1)'(1);
  assign ptr_next = (id_inc == (IDX_W + 1)'(ID_COUNT)) ? '0 : id_inc[IDX_W-1:0];

  // map ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = scan_next;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        if (req_acc) begin
          if (mode == rria_pkg::MODE_FREE) begin
            ram_re    = rel_ok;
            ram_raddr = rel_addr;
          end else begin
            ram_re    = !full;
            ram_raddr = ptr_addr;
          end
        end
      end
      S_FREE: begin
        // clear the used mark of the released identifier
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~bit_sel;
      end
      S_SCAN: begin
        if (ffz.found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | ffz.onehot;
        end else begin
          // fetch the next word while this one is checked
          ram_re = 1'b1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rria_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      ptr        <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // a waiting response stays until taken
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            if (mode == rria_pkg::MODE_FREE) begin
              granted_id <= release_id;
              status     <= rria_pkg::ST_OK;
              if (rel_ok) begin
                op_addr <= rel_addr;
                op_bit  <= BIT_W'(release_id);
                state   <= S_FREE;
              end
              // identifier outside the pool: echo it, change nothing
            end else if (full) begin
              granted_id <= '0;
              status     <= rria_pkg::ST_FULL;
            end else begin
              op_addr <= ptr_addr;
              op_bit  <= BIT_W'(ptr);
              first   <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_FREE: begin
          if (bit_set) begin
            used_count <= used_count - CNT_W'(1);
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (ffz.found) begin
            ptr        <= ptr_next;
            used_count <= used_count + CNT_W'(1);
            granted_id <= 8'(new_id);
            status     <= rria_pkg::ST_OK;
            state      <= S_IDLE;
          end else begin
            op_addr <= scan_next;
            first   <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the in-use count never passes the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_count) <= 32'(ID_COUNT))
    else $error("used count above pool size");

  // a scan only starts with a free identifier somewhere in the map
  a_scan_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !full)
    else $error("scan running on a full pool");

  // an allocate on a full pool answers full in the next cycle
  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
    req_acc && mode == rria_pkg::MODE_ALLOC && full
    |=> rsp_valid && status == rria_pkg::ST_FULL && granted_id == 8'd0)
    else $error("full allocate not answered as full");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // pool size of the block under test, and run limits
  localparam int POOL_SIZE   = 256;
  localparam int LONG_HOLD   = 80;    // cycles the response side holds off once
  localparam int STUCK_LIMIT = 3000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 24;    // settle time after the last response
  localparam int RANDOM_ITEMS = 50;

  // one expected response
  typedef struct packed {
    logic [7:0] id;
    logic       st;
  } grant_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       mode = rria_pkg::MODE_ALLOC;
  logic [7:0] release_id = 8'h00;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] granted_id;
  logic       status;

  round_robin_id_allocator #(
    .ID_COUNT(POOL_SIZE)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .release_id(release_id),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .granted_id(granted_id),
    .status    (status)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the allocator state, advanced at each accepted request
  bit     id_busy [POOL_SIZE];
  int     scan_from;
  int     busy_count;

  // responses still owed by the block, oldest first
  grant_t pending_grants[$];

  // run bookkeeping
  int     errors;
  int     stuck_cycles;
  int     n_sent;
  int     n_granted;
  int     n_full;
  int     n_released;
  int     n_idle_frees;
  int     n_fills;
  bit     quiet;           // no idling on either side
  bit     long_hold_req;   // ask the response side for one long hold-off

  // next id after v, wrapping at the pool size
  function automatic int next_id(input int v);
    return (v + 1 >= POOL_SIZE) ? 0 : v + 1;
  endfunction

  // apply one request to the shadow state and return the response it owes
  function automatic grant_t predict_grant(input logic m, input logic [7:0] rel);
    grant_t g;
    int     cand;
    g.id = rel;
    g.st = rria_pkg::ST_OK;
    if (m == rria_pkg::MODE_FREE) begin
      // freeing an idle id, or one beyond the pool, just echoes it
      if (int'(rel) < POOL_SIZE && id_busy[rel]) begin
        id_busy[rel] = 1'b0;
        busy_count--;
        n_released++;
      end else begin
        n_idle_frees++;
      end
      return g;
    end
    g.id = 8'h00;
    if (busy_count >= POOL_SIZE) begin
      // pool full: report it and leave everything as is
      g.st = rria_pkg::ST_FULL;
      n_full++;
      return g;
    end
    cand = scan_from;
    for (int t = 0; t < POOL_SIZE; t++) begin
      if (!id_busy[cand]) begin
        id_busy[cand] = 1'b1;
        busy_count++;
        scan_from = next_id(cand);
        g.id = cand[7:0];
        n_granted++;
        return g;
      end
      cand = next_id(cand);
    end
    // map and count disagree: treated as full
    g.st = rria_pkg::ST_FULL;
    n_full++;
    return g;
  endfunction

  // some id that is currently handed out, searched from a random start
  function automatic logic [7:0] pick_busy_id();
    int cand;
    cand = $urandom_range(0, POOL_SIZE - 1);
    for (int t = 0; t < POOL_SIZE; t++) begin
      if (id_busy[cand]) return cand[7:0];
      cand = next_id(cand);
    end
    return 8'($urandom);
  endfunction

  // drive one request transaction; called and returning at a falling edge
  task automatic send_req(input logic m, input logic [7:0] rel);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_valid  = 1'b1;
    mode       = m;
    release_id = rel;
    do @(posedge clk); while (req_stall);
    // accepted at this edge: the shadow state moves in request order
    pending_grants.push_back(predict_grant(m, rel));
    n_sent++;
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // one random request; free_pct is the share of frees, mostly of live ids
  task automatic send_random(input int free_pct);
    logic [7:0] rel;
    rel = 8'($urandom);
    if ($urandom_range(0, 99) < free_pct) begin
      if (busy_count > 0 && $urandom_range(0, 99) < 85) rel = pick_busy_id();
      send_req(rria_pkg::MODE_FREE, rel);
    end else begin
      send_req(rria_pkg::MODE_ALLOC, rel);
    end
  endtask

  // hold the request side until every owed response has come back
  task automatic wait_drained();
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  // handful of hand-picked transactions on a fresh pool
  task automatic test_directed();
    // first grants come out in order; release_id is a don't-care here
    send_req(rria_pkg::MODE_ALLOC, 8'h00);
    send_req(rria_pkg::MODE_ALLOC, 8'hFF);
    send_req(rria_pkg::MODE_ALLOC, 8'h5A);
    send_req(rria_pkg::MODE_ALLOC, 8'hA5);
    // free a live id, then the same one again which is a no-op
    send_req(rria_pkg::MODE_FREE, 8'h01);
    send_req(rria_pkg::MODE_FREE, 8'h01);
    // top id and a pattern id were never handed out; id 0 was
    send_req(rria_pkg::MODE_FREE, 8'hFF);
    send_req(rria_pkg::MODE_FREE, 8'h80);
    send_req(rria_pkg::MODE_FREE, 8'h00);
    // pointer sits past the last grant, so freed low ids are not reused yet
    send_req(rria_pkg::MODE_ALLOC, 8'h55);
    send_req(rria_pkg::MODE_ALLOC, 8'hAA);
    send_req(rria_pkg::MODE_FREE, 8'h7F);
    wait_drained();
  endtask

  // fill the whole pool, run into the full case, then open holes and refill
  task automatic test_pool_full();
    while (busy_count < POOL_SIZE) send_req(rria_pkg::MODE_ALLOC, 8'($urandom));
    n_fills++;
    // every id is out now: allocates report full and change nothing
    send_req(rria_pkg::MODE_ALLOC, 8'hFF);
    send_req(rria_pkg::MODE_ALLOC, 8'h00);
    wait_drained();
    send_req(rria_pkg::MODE_ALLOC, 8'($urandom));
    // holes at both ends of the range, found after the pointer wraps
    send_req(rria_pkg::MODE_FREE, 8'hFF);
    send_req(rria_pkg::MODE_FREE, 8'h00);
    send_req(rria_pkg::MODE_ALLOC, 8'h3C);
    send_req(rria_pkg::MODE_ALLOC, 8'hC3);
    send_req(rria_pkg::MODE_ALLOC, 8'h00);
    // scattered holes, then one allocate more than there is room for
    repeat (3) send_req(rria_pkg::MODE_FREE, pick_busy_id());
    repeat (4) send_req(rria_pkg::MODE_ALLOC, 8'($urandom));
    // leave some room in the pool for what follows
    repeat (POOL_SIZE / 8) send_req(rria_pkg::MODE_FREE, pick_busy_id());
    wait_drained();
  endtask

  // response side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (30) send_random(50);
    // sender stops until the block has handed back everything
    wait_drained();
  endtask

  // random traffic in phases of 50 requests, each phase with its own share of frees
  task automatic test_random_traffic();
    int free_pct;
    for (int p = 0; p < RANDOM_ITEMS / 50; p++) begin
      free_pct = $urandom_range(10, 90);
      repeat (50) send_random(free_pct);
      // now and then pause until the block is idle
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_quiet_tail();
    quiet = 1'b1;
    repeat (30) send_random(45);
    wait_drained();
  endtask

  // response side: random stall bursts plus the one long hold-off
  initial begin : rsp_stall_gen
    int burst;
    bit hold_done;
    burst = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        rsp_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      if (burst > 0) begin
        rsp_stall = 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_stall = 1'b1;
        burst = $urandom_range(0, 6);
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  // compare each response transaction with the oldest owed one
  always @(posedge clk) begin : check_grants
    grant_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_grants.size() == 0) begin
        $error("response with nothing owed: granted_id %0d status %0d", granted_id, status);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (granted_id !== want.id) begin
          $error("granted_id expected %0d got %0d", want.id, granted_id);
          errors++;
        end
        if (status !== want.st) begin
          $error("status expected %0d got %0d", want.st, status);
          errors++;
        end
      end
    end
  end

  // give up when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d responses owed",
                 stuck_cycles, pending_grants.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : main
    // fresh shadow state matches the block after reset
    for (int i = 0; i < POOL_SIZE; i++) id_busy[i] = 1'b0;
    scan_from = 0;
    busy_count = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_pool_full();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests: %0d grants, %0d pool-full, %0d frees, %0d frees of idle ids",
             n_sent, n_granted, n_full, n_released, n_idle_frees);
    $display("pool filled %0d time(s), long response hold-off and drain pauses applied",
             n_fills);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
